[hdl/anf_pkg.sv]
// anf_pkg: shared constants and types for the audio noise floor tracker
// no dependencies; imported by anf_hist, audio_noise_floor_tracker_top and anf_chk

package anf_pkg;

	// fixed field widths
	localparam int unsigned SAMPLE_W = 24;
	localparam int unsigned FLOOR_W  = 23;
	localparam int unsigned OUT_W    = 23;

	// reset values
	localparam logic [FLOOR_W-1:0] FLOOR_RESET = 23'd150;
	localparam int unsigned HIST_RESET = 200;
	// bits needed to hold the history reset value
	localparam int unsigned HIST_MIN_W = 8;

	// threshold = floor(floor(m/2) * THR_NUM / DIV_BY)
	localparam int unsigned THR_NUM = 6;
	localparam int unsigned DIV_BY  = 5;

	// control from the sequencer to the history store
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} hist_ctl_t;

endpackage

[hdl/anf_hist.sv]
// anf_hist: block peak history store, one write and one registered read port
// depends on anf_pkg (hist_ctl_t, HIST_RESET); entries not yet written read as reset value

module anf_hist #(
	parameter int unsigned DEPTH = 8,
	parameter int unsigned WIDTH = 24
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  anf_pkg::hist_ctl_t        ctl,
	input  logic [$clog2(DEPTH)-1:0]  waddr,
	input  logic [WIDTH-1:0]          wdata,
	input  logic [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]          rdata
);
	import anf_pkg::*;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [WIDTH-1:0] mem_rd_q;
	logic             vld_rd_q;

	// storage, no reset
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[waddr] <= wdata;
		end
		if (ctl.rd_en) begin
			mem_rd_q <= mem_q[raddr];
		end
	end

	// per entry written flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			vld_rd_q <= 1'b0;
		end else begin
			if (ctl.wr_en) begin
				valid_q[waddr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				vld_rd_q <= valid_q[raddr];
			end
		end
	end

	assign rdata = vld_rd_q ? mem_rd_q : WIDTH'(HIST_RESET);

endmodule

[hdl/audio_noise_floor_tracker_top.sv]
// audio_noise_floor_tracker_top: block peak tracking and noise level update
// handshake: a last beat keeps in_ready low through the history walk, divide, scale and
//   test, longer while an earlier result still waits in the output register; the result
//   is registered and shows on out_valid once the test state loads it
// throughput: one sample per cycle inside a block; block end bound by the history walk
//   (one entry per cycle through one read port), then divide, scale and test
// reset: arst_n clears peak and noise level, history reads 200, floor returns to 150

module audio_noise_floor_tracker_top #(
	parameter int unsigned HIST_DEPTH  = 8,
	parameter int unsigned SAMPLE_BITS = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_we,
	input  logic [anf_pkg::FLOOR_W-1:0]         cfg_wdata,
	// sample beats
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [anf_pkg::SAMPLE_W-1:0] sample,
	input  logic                                last,
	// result beats
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [anf_pkg::OUT_W-1:0]           noise_level,
	output logic                                level_changed,
	output logic [anf_pkg::OUT_W-1:0]           block_peak
);
	import anf_pkg::*;

	// magnitude width, history entry width, noise level width
	localparam int unsigned MAG_W = SAMPLE_BITS - 1;
	localparam int unsigned HW    = (MAG_W > HIST_MIN_W) ? MAG_W : HIST_MIN_W;
	localparam int unsigned NW    = (HW > FLOOR_W) ? HW : FLOOR_W;
	// dividend width: floor(m/2) * 6
	localparam int unsigned XW    = NW + 2;
	localparam int unsigned AW    = $clog2(HIST_DEPTH);
	localparam int unsigned CW    = AW + 1;
	localparam int unsigned SW    = HW + $clog2(HIST_DEPTH);
	localparam int unsigned PW    = XW + $clog2(HIST_DEPTH + 1);
	localparam int unsigned CMPW  = (PW > SW) ? PW : SW;
	// rounded-up reciprocal of five, exact for any dividend below 2^XW
	localparam int unsigned DIV_SH  = XW + 3;
	localparam logic [XW:0] DIV_MAG =
		(XW + 1)'(((64'd1 << DIV_SH) + 64'(DIV_BY) - 64'd1) / 64'(DIV_BY));

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_DIV,
		S_MUL,
		S_TEST
	} state_t;

	state_t state_q;

	logic [FLOOR_W-1:0] floor_q;
	logic [MAG_W-1:0]   peak_q;
	logic [MAG_W-1:0]   bpeak_q;
	logic [NW-1:0]      noise_q;
	logic [HW-1:0]      newest_q;
	logic [HW-1:0]      prior_q;
	logic [AW-1:0]      head_q;
	logic [CW-1:0]      cnt_q;
	logic               rd_vld_s1;
	logic [HW-1:0]      hmax_q;
	logic [SW-1:0]      hsum_q;
	logic [NW-1:0]      m_q;
	logic [XW-1:0]      x_q;
	logic [XW-1:0]      quo_q;
	logic [PW-1:0]      prod_q;
	logic               out_valid_q;
	logic [NW-1:0]      out_noise_q;
	logic               out_chg_q;
	logic [MAG_W-1:0]   out_peak_q;

	// sample magnitude, most negative value saturates
	logic signed [SAMPLE_BITS-1:0] sx;
	logic [SAMPLE_BITS-1:0]        ux;
	logic [SAMPLE_BITS-1:0]        nx;
	logic [MAG_W-1:0]              mag;
	logic [MAG_W-1:0]              new_peak;
	logic [HW-1:0]                 peak_h;
	logic                          do_shift;
	logic                          in_beat;
	logic                          blk_end;
	logic [AW-1:0]                 head_inc;
	logic [AW-1:0]                 head_dec;

	assign sx = SAMPLE_BITS'(sample);
	assign ux = sx;
	assign nx = ~ux + SAMPLE_BITS'(1);

	always_comb begin
		if (ux == {1'b1, {MAG_W{1'b0}}}) begin
			mag = {MAG_W{1'b1}};
		end else if (ux[SAMPLE_BITS-1]) begin
			mag = nx[MAG_W-1:0];
		end else begin
			mag = ux[MAG_W-1:0];
		end
	end

	assign new_peak = (mag > peak_q) ? mag : peak_q;
	assign peak_h   = HW'(new_peak);

	assign in_ready = (state_q == S_IDLE);
	assign in_beat  = in_valid && in_ready;
	assign blk_end  = in_beat && last;

	// shift when newest < 2*prior or newest < 2*peak
	assign do_shift = ({1'b0, newest_q} < {prior_q, 1'b0}) ||
	                  ({1'b0, newest_q} < {peak_h, 1'b0});

	assign head_inc = (head_q == AW'(HIST_DEPTH - 1)) ? '0 : head_q + AW'(1);
	assign head_dec = (head_q == '0) ? AW'(HIST_DEPTH - 1) : head_q - AW'(1);

	// history store: circular, head_q points at the oldest entry
	hist_ctl_t        hctl;
	logic [AW-1:0]    hwaddr;
	logic [AW-1:0]    hraddr;
	logic [HW-1:0]    hrdata;
	logic             walk_issue;

	assign walk_issue = (state_q == S_WALK) && (cnt_q != CW'(HIST_DEPTH));
	assign hctl.wr_en = blk_end;
	assign hctl.rd_en = walk_issue;
	// shifting retires the oldest slot, which then takes the new peak
	assign hwaddr     = do_shift ? head_q : head_dec;
	assign hraddr     = cnt_q[AW-1:0];

	anf_hist #(
		.DEPTH (HIST_DEPTH),
		.WIDTH (HW)
	) u_hist (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (hctl),
		.waddr  (hwaddr),
		.wdata  (peak_h),
		.raddr  (hraddr),
		.rdata  (hrdata)
	);

	// history max raised to the floor, and floor(m/2)*6
	logic [NW-1:0] hmax_n;
	logic [NW-1:0] floor_n;
	logic [NW-1:0] m_comb;
	logic [XW-1:0] x_comb;

	assign hmax_n  = NW'(hmax_q);
	assign floor_n = NW'(floor_q);
	assign m_comb  = (hmax_n < floor_n) ? floor_n : hmax_n;
	assign x_comb  = XW'(m_comb[NW-1:1]) * XW'(THR_NUM);

	// divide by five as a multiply by the rounded-up reciprocal
	logic [2*XW:0] div_prod;

	assign div_prod = (2 * XW + 1)'(x_q) * (2 * XW + 1)'(DIV_MAG);

	// threshold test: D*floor(x/5) <= sum is the same as floor(x/5) <= floor(sum/D)
	logic test_pass;
	logic out_free;
	logic res_load;

	assign test_pass = (CMPW'(prod_q) <= CMPW'(hsum_q)) && (m_q != noise_q);
	assign out_free  = !out_valid_q || out_ready;
	assign res_load  = (state_q == S_TEST) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			floor_q     <= FLOOR_RESET;
			peak_q      <= '0;
			bpeak_q     <= '0;
			noise_q     <= '0;
			newest_q    <= HW'(HIST_RESET);
			prior_q     <= HW'(HIST_RESET);
			head_q      <= '0;
			cnt_q       <= '0;
			rd_vld_s1   <= 1'b0;
			hmax_q      <= '0;
			hsum_q      <= '0;
			m_q         <= '0;
			x_q         <= '0;
			quo_q       <= '0;
			prod_q      <= '0;
			out_valid_q <= 1'b0;
			out_noise_q <= '0;
			out_chg_q   <= 1'b0;
			out_peak_q  <= '0;
		end else begin
			if (cfg_we) begin
				floor_q <= cfg_wdata;
			end
			// result register: load a new beat or drop the delivered one
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_beat) begin
						if (last) begin
							// close the block: write the peak, then walk the history
							bpeak_q  <= new_peak;
							peak_q   <= '0;
							newest_q <= peak_h;
							if (do_shift) begin
								prior_q <= newest_q;
								head_q  <= head_inc;
							end
							cnt_q   <= '0;
							hmax_q  <= '0;
							hsum_q  <= '0;
							state_q <= S_WALK;
						end else begin
							peak_q <= new_peak;
						end
					end
				end
				S_WALK: begin
					rd_vld_s1 <= walk_issue;
					if (walk_issue) begin
						cnt_q <= cnt_q + CW'(1);
					end
					if (rd_vld_s1) begin
						hsum_q <= hsum_q + SW'(hrdata);
						if (hrdata > hmax_q) begin
							hmax_q <= hrdata;
						end
					end else if (!walk_issue) begin
						// all entries summed
						m_q     <= m_comb;
						x_q     <= x_comb;
						quo_q   <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					quo_q   <= XW'(div_prod >> DIV_SH);
					state_q <= S_MUL;
				end
				S_MUL: begin
					prod_q  <= PW'(quo_q) * PW'(HIST_DEPTH);
					state_q <= S_TEST;
				end
				S_TEST: begin
					// hold here until the result register is free
					if (out_free) begin
						if (test_pass) begin
							noise_q <= m_q;
						end
						out_noise_q <= test_pass ? m_q : noise_q;
						out_chg_q   <= test_pass;
						out_peak_q  <= bpeak_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign noise_level   = OUT_W'(out_noise_q);
	assign level_changed = out_chg_q;
	assign block_peak    = OUT_W'(out_peak_q);

endmodule

[hdl/anf_chk.sv]
// anf_chk: port level checks for audio_noise_floor_tracker_top
// depends on anf_pkg for field widths; attached to the top level by the bind below

module anf_chk (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                last,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic [anf_pkg::OUT_W-1:0]           noise_level,
	input logic                                level_changed,
	input logic [anf_pkg::OUT_W-1:0]           block_peak
);
	import anf_pkg::*;

	logic [1:0]       pend_q;
	logic [OUT_W-1:0] last_noise_q;
	logic             blk_in;
	logic             res_out;

	assign blk_in  = in_valid && in_ready && last;
	assign res_out = out_valid && out_ready;

	// blocks closed but not yet delivered, and last delivered level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q       <= '0;
			last_noise_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, blk_in} - {1'b0, res_out};
			if (res_out) begin
				last_noise_q <= noise_level;
			end
		end
	end

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(noise_level) &&
		$stable(level_changed) && $stable(block_peak))
		else $error("result beat changed while stalled");

	// a result only for a closed block
	a_out_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("result beat without a closed block");

	// at most one block in flight plus one waiting result
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("too many closed blocks outstanding");

	// an unchanged level repeats the previous one
	a_level_kept: assert property (@(posedge clk) disable iff (!arst_n)
		res_out && !level_changed |-> noise_level == last_noise_q)
		else $error("noise level moved without level_changed");

endmodule

bind audio_noise_floor_tracker_top anf_chk u_anf_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.last          (last),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.noise_level   (noise_level),
	.level_changed (level_changed),
	.block_peak    (block_peak)
);
